FILE: sv/hidc_pkg.sv
// Shared types, constants and Q31.16 helper functions of the heat input controller.
// No dependencies; used by the datapath, the sequencer and the arithmetic units.

package hidc_pkg;

	localparam int DATA_W = 48;
	localparam int MAG_W  = 83;
	localparam int PROD_W = 96;
	localparam int DEN_W  = 94;

	typedef logic signed [DATA_W-1:0] q_t;

	localparam q_t MAX_Q = 48'sh7FFF_FFFF_FFFF;
	localparam q_t MIN_Q = 48'sh8000_0000_0000;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TEMP_THRESHOLD,
		REG_REDUCE_MODE,
		REG_LOOP_GAIN,
		REG_HEAT_BASE,
		REG_HEAT_FLOOR,
		REG_HEAT_CEILING,
		REG_RAMP_LIMIT,
		REG_TEMP_CEILING
	} cfg_reg_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_MUL_ERR,
		CMD_TAKE_P,
		CMD_LIN,
		CMD_MUL_SCALE,
		CMD_CLAMP,
		CMD_MUL_DQ,
		CMD_SLEW,
		CMD_MUL_D,
		CMD_DIV,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		logic present;
		logic above;
		logic linear;
		logic slew_on;
		logic flux_pos;
		logic mul_done;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic logic [DATA_W-1:0] mag48(input q_t v);
		logic [DATA_W-1:0] u;
		u = v;
		return v[DATA_W-1] ? (48'd0 - u) : u;
	endfunction

	// fold a 49-bit signed sum back into 48 bits
	function automatic q_t sat49(input logic signed [DATA_W:0] v);
		q_t r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? MIN_Q : MAX_Q;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// lower bound first, so crossed bounds give the upper one
	function automatic q_t clamp48(input q_t x, input q_t lo, input q_t hi);
		q_t r;
		r = x;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	// apply a sign to a magnitude and saturate
	function automatic q_t sat_mag(input logic [MAG_W-1:0] m, input logic neg);
		q_t r;
		if (neg) begin
			if (m > 83'h8000_0000_0000) r = MIN_Q;
			else r = $signed(48'd0 - m[DATA_W-1:0]);
		end else begin
			if (m > 83'h7FFF_FFFF_FFFF) r = MAX_Q;
			else r = $signed(m[DATA_W-1:0]);
		end
		return r;
	endfunction

endpackage

FILE: sv/hidc_mul.sv
// Digit-serial 48 x 48 unsigned multiplier, 16 bits of one operand per cycle.
// Depends on hidc_pkg for widths.

module hidc_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hidc_pkg::DATA_W-1:0] a,
	input  logic [hidc_pkg::DATA_W-1:0] b,
	output logic                        done,
	output logic [hidc_pkg::PROD_W-1:0] prod
);

	localparam int DIGIT_W = 16;
	localparam int DIGITS  = hidc_pkg::DATA_W / DIGIT_W;

	logic [hidc_pkg::DATA_W-1:0]         a_q;
	logic [hidc_pkg::DATA_W-1:0]         b_q;
	logic [hidc_pkg::PROD_W-1:0]         acc_q;
	logic [1:0]                          cnt_q;
	logic                                busy_q;
	logic                                done_q;
	logic [hidc_pkg::DATA_W+DIGIT_W-1:0] part;

	assign part = a_q * b_q[hidc_pkg::DATA_W-1 -: DIGIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				if (cnt_q == 2'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// most significant digit first: shift the partial sum up, add the next digit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[hidc_pkg::PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
				+ {{(hidc_pkg::PROD_W-hidc_pkg::DATA_W-DIGIT_W){1'b0}}, part};
			b_q   <= {b_q[hidc_pkg::DATA_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: sv/hidc_div.sv
// Restoring divider for heat * 2^32 / (flux * cp), one quotient bit per cycle.
// Depends on hidc_pkg for widths and the saturation helpers.

module hidc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  hidc_pkg::q_t               heat,
	input  logic [hidc_pkg::DEN_W-1:0] den,
	output logic                       done,
	output hidc_pkg::q_t               quot
);

	localparam int ITER = hidc_pkg::DATA_W;

	logic [hidc_pkg::DATA_W-1:0] hmag;
	logic                        quick;
	logic [hidc_pkg::DEN_W-1:0]  rem_q;
	logic [hidc_pkg::DEN_W-1:0]  den_q;
	logic [hidc_pkg::DATA_W-1:0] dvd_q;
	logic [hidc_pkg::DATA_W-1:0] quo_q;
	logic                        neg_q;
	hidc_pkg::q_t                res_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic                        fin_q;
	logic                        done_q;
	logic [hidc_pkg::DEN_W:0]    cand;
	logic                        ge;

	assign hmag = hidc_pkg::mag48(heat);
	// a quotient of 2^48 or more saturates: test it up front, then 48 steps suffice
	assign quick = (hmag == '0)
		|| ({{(hidc_pkg::DEN_W-32){1'b0}}, hmag[hidc_pkg::DATA_W-1:16]} >= den);

	assign cand = {rem_q, dvd_q[hidc_pkg::DATA_W-1]};
	assign ge   = cand >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !quick;
				done_q <= quick;
				cnt_q  <= 6'(ITER - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= heat[hidc_pkg::DATA_W-1];
			den_q <= den;
			quo_q <= '0;
			rem_q <= {{(hidc_pkg::DEN_W-32){1'b0}}, hmag[hidc_pkg::DATA_W-1:16]};
			dvd_q <= {hmag[15:0], 32'd0};
			if (hmag == '0) begin
				res_q <= '0;
			end else begin
				res_q <= heat[hidc_pkg::DATA_W-1] ? hidc_pkg::MIN_Q : hidc_pkg::MAX_Q;
			end
		end else if (busy_q) begin
			rem_q <= ge ? hidc_pkg::DEN_W'(cand - {1'b0, den_q}) : cand[hidc_pkg::DEN_W-1:0];
			quo_q <= {quo_q[hidc_pkg::DATA_W-2:0], ge};
			dvd_q <= {dvd_q[hidc_pkg::DATA_W-2:0], 1'b0};
		end else if (fin_q) begin
			res_q <= hidc_pkg::sat_mag({{(hidc_pkg::MAG_W-hidc_pkg::DATA_W){1'b0}}, quo_q},
				neg_q);
		end
	end

	assign done = done_q;
	assign quot = res_q;

endmodule

FILE: sv/hidc_dp.sv
// Datapath: configuration and state registers, input capture, heat law, slew
// limit, inlet temperature and result register. Uses hidc_pkg, hidc_mul, hidc_div.

module hidc_dp #(
	parameter hidc_pkg::q_t TEMP_MIN = 48'sd0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  hidc_pkg::cmd_t                cmd,
	output hidc_pkg::stat_t               st,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [hidc_pkg::DATA_W-1:0]   cfg_data,
	input  logic                          new_step,
	input  logic                          sensor_present,
	input  hidc_pkg::q_t                  sensor_temp,
	input  logic [hidc_pkg::DATA_W-2:0]   step_length,
	input  hidc_pkg::q_t                  outlet_flux,
	input  hidc_pkg::q_t                  flux_avg_temp,
	input  hidc_pkg::q_t                  area_avg_temp,
	input  logic [hidc_pkg::DATA_W-2:0]   mean_cp,
	input  logic                          out_stall,
	output logic                          out_valid,
	output hidc_pkg::q_t                  inlet_temp,
	output hidc_pkg::q_t                  heat_applied,
	output logic                          sensor_missing,
	output logic                          no_flow
);

	localparam hidc_pkg::q_t TEMP_CEIL_INIT = 48'sd327680000;

	hidc_pkg::q_t thr_q, gain_q, base_q, floor_q, ceil_q, ramp_q, tmax_q;
	logic         mode_q;
	hidc_pkg::q_t heat_last_q, heat_prev_q;

	logic                        present_q;
	hidc_pkg::q_t                ts_q, flux_q, tflux_q, tarea_q;
	logic [hidc_pkg::DATA_W-2:0] dt_q, cp_q;

	hidc_pkg::q_t heat_q, p_q;
	logic         mul_neg_q;

	logic         out_valid_q;
	hidc_pkg::q_t inlet_temp_q, heat_applied_q;
	logic         sensor_missing_q, no_flow_q;

	logic signed [hidc_pkg::DATA_W:0] err;
	logic signed [hidc_pkg::DATA_W:0] f_s;
	logic [hidc_pkg::DATA_W-1:0]      f_mag;
	logic                             flux_pos;

	logic                        mul_start, mul_neg, mul_done;
	logic [hidc_pkg::DATA_W-1:0] mul_a, mul_b;
	logic [hidc_pkg::PROD_W-1:0] mul_prod;
	logic [hidc_pkg::PROD_W:0]   rnd;
	hidc_pkg::q_t                prod_q;

	logic         div_start, div_done;
	hidc_pkg::q_t div_quot;

	hidc_pkg::q_t                     lin_q, slew_lo, slew_hi, tin_c;
	logic signed [hidc_pkg::DATA_W:0] tsum;

	assign err      = {ts_q[47], ts_q} - {thr_q[47], thr_q};
	assign flux_pos = !flux_q[47] && (flux_q != '0);

	// scale factor max(0, 1.0 - P)
	assign f_s   = 49'sd65536 - {p_q[47], p_q};
	assign f_mag = f_s[hidc_pkg::DATA_W] ? '0 : f_s[hidc_pkg::DATA_W-1:0];

	always_comb begin
		mul_start = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		mul_neg   = 1'b0;
		case (cmd)
			hidc_pkg::CMD_MUL_ERR: begin
				mul_a   = hidc_pkg::mag48(gain_q);
				mul_b   = err[hidc_pkg::DATA_W-1:0];
				mul_neg = gain_q[47];
			end
			hidc_pkg::CMD_MUL_SCALE: begin
				mul_a   = hidc_pkg::mag48(base_q);
				mul_b   = f_mag;
				mul_neg = base_q[47];
			end
			hidc_pkg::CMD_MUL_DQ: begin
				mul_a = ramp_q;
				mul_b = {1'b0, dt_q};
			end
			hidc_pkg::CMD_MUL_D: begin
				mul_a = flux_q;
				mul_b = {1'b0, cp_q};
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	hidc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// round halves away from zero on the magnitude, then apply the sign
	assign rnd    = {1'b0, mul_prod} + 97'h8000;
	assign prod_q = hidc_pkg::sat_mag({2'b00, rnd[hidc_pkg::PROD_W:16]}, mul_neg_q);

	assign div_start = (cmd == hidc_pkg::CMD_DIV);

	hidc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.heat   (heat_q),
		.den    (mul_prod[hidc_pkg::DEN_W-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign lin_q   = hidc_pkg::sat49({base_q[47], base_q} - {p_q[47], p_q});
	assign slew_lo = hidc_pkg::sat49({heat_prev_q[47], heat_prev_q} - {p_q[47], p_q});
	assign slew_hi = hidc_pkg::sat49({heat_prev_q[47], heat_prev_q} + {p_q[47], p_q});
	assign tsum    = {tflux_q[47], tflux_q} + {div_quot[47], div_quot};
	assign tin_c   = hidc_pkg::clamp48(hidc_pkg::sat49(tsum), TEMP_MIN, tmax_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= '0;
			mode_q      <= 1'b0;
			gain_q      <= '0;
			base_q      <= '0;
			floor_q     <= '0;
			ceil_q      <= '0;
			ramp_q      <= '0;
			tmax_q      <= TEMP_CEIL_INIT;
			heat_last_q <= '0;
			heat_prev_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hidc_pkg::REG_TEMP_THRESHOLD: thr_q   <= cfg_data;
					hidc_pkg::REG_REDUCE_MODE:    mode_q  <= cfg_data[0];
					hidc_pkg::REG_LOOP_GAIN:      gain_q  <= cfg_data;
					hidc_pkg::REG_HEAT_BASE:      base_q  <= cfg_data;
					hidc_pkg::REG_HEAT_FLOOR:     floor_q <= cfg_data;
					hidc_pkg::REG_HEAT_CEILING:   ceil_q  <= cfg_data;
					hidc_pkg::REG_RAMP_LIMIT:     ramp_q  <= cfg_data;
					hidc_pkg::REG_TEMP_CEILING:   tmax_q  <= cfg_data;
					default: ;
				endcase
			end
			if (accept && new_step) heat_prev_q <= heat_last_q;
			if (cmd == hidc_pkg::CMD_FIN) begin
				heat_last_q <= heat_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			present_q <= sensor_present;
			ts_q      <= sensor_temp;
			dt_q      <= step_length;
			flux_q    <= outlet_flux;
			tflux_q   <= flux_avg_temp;
			tarea_q   <= area_avg_temp;
			cp_q      <= mean_cp;
			heat_q    <= base_q;
		end
		if (mul_start) mul_neg_q <= mul_neg;
		case (cmd)
			hidc_pkg::CMD_TAKE_P: p_q    <= prod_q;
			hidc_pkg::CMD_LIN:    heat_q <= hidc_pkg::clamp48(lin_q, floor_q, ceil_q);
			hidc_pkg::CMD_CLAMP:  heat_q <= hidc_pkg::clamp48(p_q, floor_q, ceil_q);
			hidc_pkg::CMD_SLEW:   heat_q <= hidc_pkg::clamp48(heat_q, slew_lo, slew_hi);
			hidc_pkg::CMD_FIN: begin
				inlet_temp_q     <= flux_pos ? tin_c : tarea_q;
				heat_applied_q   <= heat_q;
				sensor_missing_q <= !present_q;
				no_flow_q        <= !flux_pos;
			end
			default: ;
		endcase
	end

	assign st.present  = present_q;
	assign st.above    = !err[hidc_pkg::DATA_W] && (err != '0);
	assign st.linear   = mode_q;
	assign st.slew_on  = !ramp_q[47] && (ramp_q != '0) && (dt_q != '0);
	assign st.flux_pos = flux_pos;
	assign st.mul_done = mul_done;
	assign st.div_done = div_done;
	assign st.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign inlet_temp     = inlet_temp_q;
	assign heat_applied   = heat_applied_q;
	assign sensor_missing = sensor_missing_q;
	assign no_flow        = no_flow_q;

endmodule

FILE: sv/hidc_ctrl.sv
// Sequencer: walks one item through the heat law, slew limit and inlet division,
// issuing at most one datapath command a cycle. Uses hidc_pkg for commands and status.

module hidc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  hidc_pkg::stat_t st,
	output hidc_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_MUL_P,
		ST_TAKE_P,
		ST_SCALE_MUL,
		ST_TAKE_F,
		ST_Q_DONE,
		ST_DQ_MUL,
		ST_TAKE_DQ,
		ST_POST,
		ST_D_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t         state_q;
	hidc_pkg::cmd_t cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= hidc_pkg::CMD_NONE;
		end else begin
			cmd_q <= hidc_pkg::CMD_NONE;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (st.present && st.above) begin
						cmd_q   <= hidc_pkg::CMD_MUL_ERR;
						state_q <= ST_MUL_P;
					end else if (st.present && st.slew_on) begin
						cmd_q   <= hidc_pkg::CMD_MUL_DQ;
						state_q <= ST_DQ_MUL;
					end else if (st.flux_pos) begin
						cmd_q   <= hidc_pkg::CMD_MUL_D;
						state_q <= ST_D_MUL;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MUL_P: begin
					if (st.mul_done) begin
						cmd_q   <= hidc_pkg::CMD_TAKE_P;
						state_q <= ST_TAKE_P;
					end
				end
				ST_TAKE_P: begin
					if (st.linear) begin
						cmd_q   <= hidc_pkg::CMD_LIN;
						state_q <= ST_Q_DONE;
					end else begin
						cmd_q   <= hidc_pkg::CMD_MUL_SCALE;
						state_q <= ST_SCALE_MUL;
					end
				end
				ST_SCALE_MUL: begin
					if (st.mul_done) begin
						cmd_q   <= hidc_pkg::CMD_TAKE_P;
						state_q <= ST_TAKE_F;
					end
				end
				ST_TAKE_F: begin
					cmd_q   <= hidc_pkg::CMD_CLAMP;
					state_q <= ST_Q_DONE;
				end
				ST_Q_DONE: begin
					if (st.slew_on) begin
						cmd_q   <= hidc_pkg::CMD_MUL_DQ;
						state_q <= ST_DQ_MUL;
					end else if (st.flux_pos) begin
						cmd_q   <= hidc_pkg::CMD_MUL_D;
						state_q <= ST_D_MUL;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DQ_MUL: begin
					if (st.mul_done) begin
						cmd_q   <= hidc_pkg::CMD_TAKE_P;
						state_q <= ST_TAKE_DQ;
					end
				end
				ST_TAKE_DQ: begin
					cmd_q   <= hidc_pkg::CMD_SLEW;
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (st.flux_pos) begin
						cmd_q   <= hidc_pkg::CMD_MUL_D;
						state_q <= ST_D_MUL;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_D_MUL: begin
					if (st.mul_done) begin
						cmd_q   <= hidc_pkg::CMD_DIV;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (st.div_done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the result register is free
					if (st.out_free) begin
						cmd_q   <= hidc_pkg::CMD_FIN;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign cmd      = cmd_q;

`ifndef SYNTHESIS
	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		st.mul_done |-> (state_q == ST_MUL_P || state_q == ST_SCALE_MUL
			|| state_q == ST_DQ_MUL || state_q == ST_D_MUL))
		else $error("multiplier finished outside a wait state");
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == hidc_pkg::CMD_FIN) |-> st.out_free)
		else $error("result written over one not yet transferred");
`endif

endmodule

FILE: sv/heat_input_deadband_controller_top.sv
// Heat input controller with dead band and slew limit: top level.
// Joins the sequencer hidc_ctrl and the datapath hidc_dp; uses hidc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one solver iteration's step data;
//   a transfer happens on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns one result per item, held
//   in an output register until transferred.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
//   has it written only while no item is in flight; the block does not check it.
// Sequence:
//   One item at a time. The time from transfer to result depends on which of the
//   heat law, the slew limit and the inlet division run: up to four products on
//   a 16-bit-per-cycle multiplier and a 48-step restoring divider.
//   in_stall is high from the transfer until the result has been written.
// Reset: arst_n clears the registers to their reset values, the heat history
//   to zero and the output to empty; an item in flight is dropped, none is invented.
// Stall: while out_stall holds a result, the block finishes the next item and
//   waits with it until the output register is free.

module heat_input_deadband_controller_top #(
	parameter logic signed [47:0] TEMP_MIN = 48'sd0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        new_step,
	input  logic                        sensor_present,
	input  logic signed [47:0]          sensor_temp,
	input  logic [46:0]                 step_length,
	input  logic signed [47:0]          outlet_flux,
	input  logic signed [47:0]          flux_avg_temp,
	input  logic signed [47:0]          area_avg_temp,
	input  logic [46:0]                 mean_cp,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [47:0]          inlet_temp,
	output logic signed [47:0]          heat_applied,
	output logic                        sensor_missing,
	output logic                        no_flow,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [47:0]                 cfg_data
);

	hidc_pkg::cmd_t  cmd;
	hidc_pkg::stat_t st;
	logic            accept;

	assign accept = in_valid && !in_stall;

	hidc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	hidc_dp #(
		.TEMP_MIN (TEMP_MIN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.new_step       (new_step),
		.sensor_present (sensor_present),
		.sensor_temp    (sensor_temp),
		.step_length    (step_length),
		.outlet_flux    (outlet_flux),
		.flux_avg_temp  (flux_avg_temp),
		.area_avg_temp  (area_avg_temp),
		.mean_cp        (mean_cp),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.inlet_temp     (inlet_temp),
		.heat_applied   (heat_applied),
		.sensor_missing (sensor_missing),
		.no_flow        (no_flow)
	);

endmodule

FILE: dv/heat_input_deadband_controller_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for heat_input_deadband_controller_top: directed and random solver
// iterations, each result checked against a Q31.16 model of the heat law and inlet temperature.
// Depends on hidc_pkg and the controller RTL.

localparam bit     MODE_SCALE  = 1'b0;
localparam bit     MODE_LINEAR = 1'b1;
localparam longint SAT_HI      = 64'sd140737488355327;
localparam longint SAT_LO      = -64'sd140737488355328;
localparam longint ONE_Q       = 64'sd65536;
localparam longint TEMP_MIN    = 64'sd0;

typedef struct packed {
	logic         new_step;
	logic         sensor_present;
	hidc_pkg::q_t sensor_temp;
	logic [46:0]  step_length;
	hidc_pkg::q_t outlet_flux;
	hidc_pkg::q_t flux_avg_temp;
	hidc_pkg::q_t area_avg_temp;
	logic [46:0]  mean_cp;
} step_t;

typedef struct packed {
	hidc_pkg::q_t inlet_temp;
	hidc_pkg::q_t heat_applied;
	logic         sensor_missing;
	logic         no_flow;
} outcome_t;

class inlet_heat_checker;
	longint   temp_threshold, loop_gain, heat_base, heat_floor, heat_ceiling;
	longint   ramp_limit, temp_ceiling;
	bit       reduce_mode;
	longint   heat_last, heat_prev;
	outcome_t pending_outcomes[$];
	int       mismatches;

	function new();
		temp_threshold = 0;
		reduce_mode    = MODE_SCALE;
		loop_gain      = 0;
		heat_base      = 0;
		heat_floor     = 0;
		heat_ceiling   = 0;
		ramp_limit     = 0;
		temp_ceiling   = 64'sd327680000;
		heat_last      = 0;
		heat_prev      = 0;
		mismatches     = 0;
	endfunction

	function int pending();
		return pending_outcomes.size();
	endfunction

	function void set_reg(hidc_pkg::cfg_reg_t idx, logic [47:0] val);
		longint v;
		v = $signed(val);
		case (idx)
		hidc_pkg::REG_TEMP_THRESHOLD: temp_threshold = v;
		hidc_pkg::REG_REDUCE_MODE:    reduce_mode = val[0];
		hidc_pkg::REG_LOOP_GAIN:      loop_gain = v;
		hidc_pkg::REG_HEAT_BASE:      heat_base = v;
		hidc_pkg::REG_HEAT_FLOOR:     heat_floor = v;
		hidc_pkg::REG_HEAT_CEILING:   heat_ceiling = v;
		hidc_pkg::REG_RAMP_LIMIT:     ramp_limit = v;
		hidc_pkg::REG_TEMP_CEILING:   temp_ceiling = v;
		default: ;
		endcase
	endfunction

	function longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function longint saturate(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// lower bound first, so crossed bounds leave the upper one
	function longint clamp(longint x, longint lo, longint hi);
		longint r;
		r = x;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	function longint apply_sign(bit [127:0] m, bit neg);
		if (neg) begin
			if (m > 128'h8000_0000_0000) return SAT_LO;
			return -$signed(m[63:0]);
		end
		if (m > 128'h7FFF_FFFF_FFFF) return SAT_HI;
		return $signed(m[63:0]);
	endfunction

	// exact product, rounded half away from zero to 16 fraction bits
	function longint round_product(longint a, longint b);
		bit [127:0] p;
		p = 128'(magnitude(a)) * 128'(magnitude(b));
		p = (p + 128'h8000) >> 16;
		return apply_sign(p, (a < 0) != (b < 0));
	endfunction

	// heat * 2^32 / (flux * cp), truncated toward zero; flux is positive here
	function longint heat_per_flow(longint heat, longint flux, longint cp);
		bit [127:0] num, den;
		if (heat == 0) return 0;
		den = 128'(flux) * 128'(cp);
		if (den == 0) return heat < 0 ? SAT_LO : SAT_HI;
		num = 128'(magnitude(heat)) << 32;
		return apply_sign(num / den, heat < 0);
	endfunction

	function void absorb_step(step_t s);
		longint   ts, dt, flux, err_gain, factor, swing, heat, tin;
		outcome_t want;
		ts   = $signed(s.sensor_temp);
		dt   = s.step_length;
		flux = $signed(s.outlet_flux);
		if (s.new_step) heat_prev = heat_last;
		heat = heat_base;
		if (s.sensor_present) begin
			if (ts > temp_threshold) begin
				err_gain = round_product(loop_gain, ts - temp_threshold);
				if (reduce_mode == MODE_LINEAR) begin
					heat = clamp(saturate(heat_base - err_gain), heat_floor, heat_ceiling);
				end else begin
					factor = ONE_Q - err_gain;
					if (factor < 0) factor = 0;
					heat = clamp(round_product(heat_base, factor), heat_floor, heat_ceiling);
				end
			end
			if (ramp_limit > 0 && dt != 0) begin
				swing = round_product(ramp_limit, dt);
				heat  = clamp(heat, saturate(heat_prev - swing), saturate(heat_prev + swing));
			end
		end
		heat_last = heat;
		if (flux > 0) begin
			tin = saturate($signed(s.flux_avg_temp) + heat_per_flow(heat, flux, s.mean_cp));
			tin = clamp(tin, TEMP_MIN, temp_ceiling);
		end else begin
			tin = $signed(s.area_avg_temp);
		end
		want.inlet_temp     = tin[47:0];
		want.heat_applied   = heat[47:0];
		want.sensor_missing = !s.sensor_present;
		want.no_flow        = !(flux > 0);
		pending_outcomes.push_back(want);
	endfunction

	task report_mismatch(string what);
		$display("%0t: result mismatch: %s", $time, what);
		mismatches++;
	endtask

	task check_outcome(outcome_t got);
		outcome_t want;
		if (pending_outcomes.size() == 0) begin
			report_mismatch("result transfer with no step in flight");
			return;
		end
		want = pending_outcomes.pop_front();
		if (got.inlet_temp !== want.inlet_temp)
			report_mismatch($sformatf("inlet_temp %0d, expected %0d",
				$signed(got.inlet_temp), $signed(want.inlet_temp)));
		if (got.heat_applied !== want.heat_applied)
			report_mismatch($sformatf("heat_applied %0d, expected %0d",
				$signed(got.heat_applied), $signed(want.heat_applied)));
		if (got.sensor_missing !== want.sensor_missing)
			report_mismatch($sformatf("sensor_missing %b, expected %b",
				got.sensor_missing, want.sensor_missing));
		if (got.no_flow !== want.no_flow)
			report_mismatch($sformatf("no_flow %b, expected %b", got.no_flow, want.no_flow));
	endtask
endclass

module heat_input_deadband_controller_top_test;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int PHASES         = 10;
	localparam int PHASE_STEPS    = 103;

	localparam int SET_BASELINE = 0;
	localparam int SET_TYPICAL  = 1;
	localparam int SET_WILD     = 2;
	localparam int SET_TOP      = 3;
	localparam int SET_BOTTOM   = 4;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              new_step;
	logic              sensor_present;
	logic signed [47:0] sensor_temp;
	logic [46:0]       step_length;
	logic signed [47:0] outlet_flux;
	logic signed [47:0] flux_avg_temp;
	logic signed [47:0] area_avg_temp;
	logic [46:0]       mean_cp;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [47:0] inlet_temp;
	logic signed [47:0] heat_applied;
	logic              sensor_missing;
	logic              no_flow;
	logic              cfg_we;
	hidc_pkg::cfg_reg_t cfg_index;
	logic [47:0]       cfg_data;

	logic [47:0]       setting [8];
	bit                gaps_on;
	bit                stalls_on;
	int                quiet_cycles = 0;
	inlet_heat_checker board;

	heat_input_deadband_controller_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.new_step       (new_step),
		.sensor_present (sensor_present),
		.sensor_temp    (sensor_temp),
		.step_length    (step_length),
		.outlet_flux    (outlet_flux),
		.flux_avg_temp  (flux_avg_temp),
		.area_avg_temp  (area_avg_temp),
		.mean_cp        (mean_cp),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.inlet_temp     (inlet_temp),
		.heat_applied   (heat_applied),
		.sensor_missing (sensor_missing),
		.no_flow        (no_flow),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	always @(negedge clk) out_stall <= stalls_on && ($urandom_range(99) < 8);

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_outcome({inlet_temp, heat_applied, sensor_missing, no_flow});

	// give up after a long spell with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic hidc_pkg::q_t q16(input int whole);
		longint v;
		v = longint'(whole) * ONE_Q;
		return v[47:0];
	endfunction

	function automatic hidc_pkg::q_t around(input hidc_pkg::q_t centre,
			input int unsigned spread);
		longint v;
		v = longint'(centre) + longint'($urandom_range(2 * spread)) - longint'(spread);
		return v[47:0];
	endfunction

	function automatic logic [47:0] any48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	function automatic step_t mk(input bit ns, input bit pres, input hidc_pkg::q_t ts,
			input logic [46:0] dt, input hidc_pkg::q_t flux, input hidc_pkg::q_t tf,
			input hidc_pkg::q_t ta, input logic [46:0] cp);
		return {ns, pres, ts, dt, flux, tf, ta, cp};
	endfunction

	function automatic step_t random_step();
		step_t       s;
		logic [47:0] r;
		int unsigned pick;
		if ($urandom_range(99) < 15) begin
			// noise: every field anywhere in its range
			s.new_step       = $urandom_range(1) != 0;
			s.sensor_present = $urandom_range(1) != 0;
			s.sensor_temp    = any48();
			r                = any48();
			s.step_length    = r[46:0];
			s.outlet_flux    = any48();
			s.flux_avg_temp  = any48();
			s.area_avg_temp  = any48();
			r                = any48();
			s.mean_cp        = r[46:0];
		end else begin
			s.new_step       = $urandom_range(3) == 0;
			s.sensor_present = $urandom_range(9) != 0;
			s.sensor_temp    = around(board.temp_threshold[47:0], 60 * 65536);
			s.step_length    = ($urandom_range(19) == 0) ? 47'd0
				: 47'($urandom_range(2 * 65536, 1));
			pick = $urandom_range(9);
			if (pick == 0) s.outlet_flux = '0;
			else if (pick == 1) s.outlet_flux = around(q16(-1), 65535);
			else s.outlet_flux = around(q16(1), 65535);
			s.flux_avg_temp  = around(q16(300), 100 * 65536);
			s.area_avg_temp  = around(q16(300), 100 * 65536);
			s.mean_cp        = ($urandom_range(49) == 0) ? 47'd0
				: 47'($urandom_range(4000 * 65536, 500 * 65536));
		end
		return s;
	endfunction

	task automatic choose_settings(input int kind, input bit mode);
		setting[hidc_pkg::REG_REDUCE_MODE] = {47'd0, mode};
		case (kind)
		SET_BASELINE: begin
			setting[hidc_pkg::REG_TEMP_THRESHOLD] = q16(300);
			setting[hidc_pkg::REG_LOOP_GAIN]      = q16(20);
			setting[hidc_pkg::REG_HEAT_BASE]      = q16(1000);
			setting[hidc_pkg::REG_HEAT_FLOOR]     = q16(100);
			setting[hidc_pkg::REG_HEAT_CEILING]   = q16(1500);
			setting[hidc_pkg::REG_RAMP_LIMIT]     = q16(200);
			setting[hidc_pkg::REG_TEMP_CEILING]   = q16(5000);
		end
		SET_TYPICAL: begin
			setting[hidc_pkg::REG_TEMP_THRESHOLD] = around(q16(300), 20 * 65536);
			// scale mode wants a gain well below one per kelvin
			setting[hidc_pkg::REG_LOOP_GAIN]      = (mode == MODE_LINEAR)
				? around(q16(25), 24 * 65536) : around(48'sd3300, 3270);
			setting[hidc_pkg::REG_HEAT_BASE]      = q16($urandom_range(3000, 200));
			setting[hidc_pkg::REG_HEAT_FLOOR]     = q16($urandom_range(1500, 0));
			setting[hidc_pkg::REG_HEAT_CEILING]   = q16($urandom_range(4000, 1000));
			setting[hidc_pkg::REG_RAMP_LIMIT]     = ($urandom_range(9) < 3)
				? around(q16(-10), 10 * 65536) : q16($urandom_range(2000, 10));
			setting[hidc_pkg::REG_TEMP_CEILING]   = ($urandom_range(4) == 0)
				? around(q16(320), 30 * 65536) : around(q16(5000), 1000 * 65536);
		end
		SET_WILD: begin
			setting[hidc_pkg::REG_REDUCE_MODE]    = {47'd0, 1'($urandom_range(1))};
			setting[hidc_pkg::REG_TEMP_THRESHOLD] = any48();
			setting[hidc_pkg::REG_LOOP_GAIN]      = any48();
			setting[hidc_pkg::REG_HEAT_BASE]      = any48();
			setting[hidc_pkg::REG_HEAT_FLOOR]     = any48();
			setting[hidc_pkg::REG_HEAT_CEILING]   = any48();
			setting[hidc_pkg::REG_RAMP_LIMIT]     = any48();
			setting[hidc_pkg::REG_TEMP_CEILING]   = any48();
		end
		SET_TOP: begin
			setting[hidc_pkg::REG_TEMP_THRESHOLD] = hidc_pkg::MAX_Q;
			setting[hidc_pkg::REG_LOOP_GAIN]      = hidc_pkg::MAX_Q;
			setting[hidc_pkg::REG_HEAT_BASE]      = hidc_pkg::MAX_Q;
			setting[hidc_pkg::REG_HEAT_FLOOR]     = hidc_pkg::MIN_Q;
			setting[hidc_pkg::REG_HEAT_CEILING]   = hidc_pkg::MAX_Q;
			setting[hidc_pkg::REG_RAMP_LIMIT]     = hidc_pkg::MAX_Q;
			setting[hidc_pkg::REG_TEMP_CEILING]   = hidc_pkg::MAX_Q;
		end
		default: begin
			// crossed heat and temperature clamps
			setting[hidc_pkg::REG_TEMP_THRESHOLD] = hidc_pkg::MIN_Q;
			setting[hidc_pkg::REG_LOOP_GAIN]      = hidc_pkg::MIN_Q;
			setting[hidc_pkg::REG_HEAT_BASE]      = hidc_pkg::MIN_Q;
			setting[hidc_pkg::REG_HEAT_FLOOR]     = hidc_pkg::MAX_Q;
			setting[hidc_pkg::REG_HEAT_CEILING]   = hidc_pkg::MIN_Q;
			setting[hidc_pkg::REG_RAMP_LIMIT]     = hidc_pkg::MIN_Q;
			setting[hidc_pkg::REG_TEMP_CEILING]   = hidc_pkg::MIN_Q;
		end
		endcase
	endtask

	task automatic load_settings();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= hidc_pkg::cfg_reg_t'(i);
			cfg_data  <= setting[i];
			@(negedge clk);
			board.set_reg(hidc_pkg::cfg_reg_t'(i), setting[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(input step_t s);
		while (gaps_on && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{new_step, sensor_present, sensor_temp, step_length, outlet_flux,
			flux_avg_temp, area_avg_temp, mean_cp} <= s;
		do @(posedge clk); while (in_stall);
		board.absorb_step(s);
		@(negedge clk);
	endtask

	// hold the input until every expected result has been transferred
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		board          = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		new_step       = 1'b0;
		sensor_present = 1'b0;
		sensor_temp    = '0;
		step_length    = '0;
		outlet_flux    = '0;
		flux_avg_temp  = '0;
		area_avg_temp  = '0;
		mean_cp        = '0;
		cfg_we         = 1'b0;
		cfg_index      = hidc_pkg::REG_TEMP_THRESHOLD;
		cfg_data       = '0;
		gaps_on        = 1'b1;
		stalls_on      = 1'b1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero heat with zero heat capacity, then no flow
		send_item(mk(1'b1, 1'b1, q16(310), 47'd6554, q16(1), q16(300), q16(290), 47'd0));
		send_item(mk(1'b0, 1'b0, q16(250), 47'd0, q16(-1), q16(300), q16(290), 47'd65536000));

		drain();
		choose_settings(SET_BASELINE, MODE_LINEAR);
		load_settings();
		send_item(mk(1'b1, 1'b0, q16(350), 47'd6554, q16(1), q16(300), q16(290),
			47'd65536000));
		send_item(mk(1'b1, 1'b1, q16(290), 47'd6554, q16(1), q16(300), q16(290),
			47'd65536000));
		send_item(mk(1'b1, 1'b1, q16(310), 47'd6554, q16(1), q16(300), q16(290),
			47'd65536000));
		send_item(mk(1'b0, 1'b1, q16(400), 47'd6554, q16(1), q16(300), q16(290),
			47'd65536000));
		send_item(mk(1'b0, 1'b1, q16(400), 47'd0, q16(1), q16(300), q16(290),
			47'd65536000));
		send_item(mk(1'b1, 1'b1, q16(305), 47'd6554, '0, q16(300), q16(290), 47'd65536000));
		send_item(mk(1'b0, 1'b1, q16(305), 47'd6554, hidc_pkg::MIN_Q, q16(300), q16(291),
			47'd65536000));
		send_item(mk(1'b0, 1'b0, q16(300), 47'd6554, q16(1), q16(300), q16(290), 47'd0));
		send_item(mk(1'b1, 1'b1, hidc_pkg::MAX_Q, {47{1'b1}}, hidc_pkg::MAX_Q,
			hidc_pkg::MIN_Q, hidc_pkg::MAX_Q, {47{1'b1}}));
		send_item(mk(1'b0, 1'b1, hidc_pkg::MIN_Q, 47'd0, 48'sd1, hidc_pkg::MAX_Q,
			hidc_pkg::MIN_Q, 47'd1));
		send_item(mk(1'b1, 1'b1, q16(301), 47'd65536, q16(2), q16(4990), q16(300),
			47'd65536));

		drain();
		choose_settings(SET_BOTTOM, MODE_SCALE);
		load_settings();
		send_item(mk(1'b1, 1'b1, '0, 47'd6554, q16(1), q16(300), q16(290), 47'd65536000));
		send_item(mk(1'b0, 1'b0, q16(300), 47'd6554, q16(1), q16(300), q16(290), 47'd0));
		send_item(mk(1'b1, 1'b1, hidc_pkg::MAX_Q, {47{1'b1}}, hidc_pkg::MAX_Q,
			hidc_pkg::MAX_Q, hidc_pkg::MIN_Q, {47{1'b1}}));

		drain();
		choose_settings(SET_TOP, MODE_LINEAR);
		load_settings();
		send_item(mk(1'b1, 1'b1, hidc_pkg::MAX_Q, {47{1'b1}}, q16(1), q16(300), q16(290),
			47'd65536000));
		send_item(mk(1'b0, 1'b1, q16(300), {47{1'b1}}, hidc_pkg::MAX_Q, hidc_pkg::MAX_Q,
			hidc_pkg::MAX_Q, 47'd1));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
			2:       choose_settings(SET_TOP, MODE_SCALE);
			3:       choose_settings(SET_BOTTOM, MODE_LINEAR);
			6, 8:    choose_settings(SET_WILD, MODE_SCALE);
			default: choose_settings(SET_TYPICAL, ph[0]);
			endcase
			load_settings();
			// one phase runs back to back on both sides
			gaps_on   = (ph != 5);
			stalls_on = (ph != 5);
			for (int k = 0; k < PHASE_STEPS; k++) begin
				if (ph == 4 && k == PHASE_STEPS / 2) drain();
				send_item(random_step());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
